>>> rtl/cml_pkg.sv
package cml_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_W        = 18;
  localparam int unsigned OUT_W         = 28;
  localparam int unsigned OUT_FRAC_W    = 13;
  localparam int unsigned NORM_SHIFT    = 13;
  localparam int unsigned GAIN_W        = 18;
  localparam int unsigned LANES_MAX     = 4;

  // 0.607252935 truncated to 18 fraction bits.
  localparam logic [GAIN_W-1:0] GAIN_RAW = 18'd159187;
  localparam logic [DATA_W-1:0] UNIT_RAW = 32'h1 << FRAC_W;

  localparam int unsigned DEF_LANES         = 4;
  localparam int unsigned DEF_LOG2_POINTS   = 12;
  localparam int unsigned DEF_CORDIC_STAGES = 16;

  typedef enum logic {
    MODE_CORDIC = 1'b0,
    MODE_APPROX = 1'b1
  } cml_mode_e;

  typedef struct packed {
    logic en;
    logic approx;
  } cml_cell_ctrl_t;

endpackage

>>> rtl/cml_cell.sv
module cml_cell import cml_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  cml_cell_ctrl_t      ctrl_i,
  input  logic [DATA_W-1:0]   x_i,
  input  logic [DATA_W-1:0]   y_i,
  output logic [DATA_W-1:0]   x_o,
  output logic [DATA_W-1:0]   y_o
);

  logic [DATA_W-1:0] xs, ys;
  logic [DATA_W-1:0] x_d, y_d, x_q, y_q;
  logic              y_pos;

  assign xs    = DATA_W'($signed(x_i) >>> SHIFT);
  assign ys    = DATA_W'($signed(y_i) >>> SHIFT);
  assign y_pos = !y_i[DATA_W-1] && (y_i != '0);

  always_comb begin
    if (ctrl_i.approx) begin
      // The approximate magnitude rides through the chain untouched.
      x_d = x_i;
      y_d = y_i;
    end else if (y_pos) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

>>> rtl/cml_finish.sv
module cml_finish import cml_pkg::*; (
  input  logic                clk_i,
  input  cml_cell_ctrl_t      ctrl_i,
  input  logic [DATA_W-1:0]   x_i,
  output logic [OUT_W-1:0]    mag_o
);

  localparam int unsigned DROP = FRAC_W - OUT_FRAC_W;
  localparam int unsigned PROD_W = DATA_W + GAIN_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic [DATA_W-1:0]        raw_d, raw_q, norm;
  logic [OUT_W-1:0]         mag_d, mag_q;

  assign prod  = $signed(x_i) * $signed({1'b0, GAIN_RAW});
  assign raw_d = ctrl_i.approx ? x_i : prod[FRAC_W+DATA_W-1:FRAC_W];

  assign norm  = DATA_W'($signed(raw_q) >>> NORM_SHIFT) + UNIT_RAW;
  assign mag_d = norm[DATA_W-1] ? '0 : OUT_W'(norm[DATA_W-1:DROP]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      raw_q <= raw_d;
      mag_q <= mag_d;
    end
  end

  assign mag_o = mag_q;

endmodule

>>> rtl/complex_magnitude_lanes_core.sv
// Magnitude of up to four complex bins per beat.
// Input channel: in_valid_i with re_laneK_i / im_laneK_i (signed, 18 fraction
// bits); the core raises in_stall_o to hold a beat off. Output channel:
// out_valid_o with mag_laneK_o (unsigned, 13 fraction bits) and frame_end_o;
// the receiver raises out_stall_i. Lanes at or above LANES read as zero.
// cfg_we_i writes cfg_wdata_i into the mode bit: 0 gives the CORDIC magnitude,
// 1 gives max + min/4 + min/8. Write it only while the pipe is empty.
// The pipe holds one input stage, one cell per CORDIC iteration, a gain multiply
// stage and the output register. Throughput is one beat per cycle while the output
// beat is not stalled, set by the chain of iteration cells, one per stage.
// frame_end_o marks every (2**LOG2_POINTS / LANES)-th beat.
// While the output beat is stalled the whole pipe holds and the input is
// stalled too; beats are never dropped or repeated.
// Reset empties the pipe, clears the beat counter and selects CORDIC mode.
module complex_magnitude_lanes_core import cml_pkg::*; #(
  parameter int unsigned LANES         = DEF_LANES,
  parameter int unsigned LOG2_POINTS   = DEF_LOG2_POINTS,
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [DATA_W-1:0]   re_lane0_i,
  input  logic [DATA_W-1:0]   im_lane0_i,
  input  logic [DATA_W-1:0]   re_lane1_i,
  input  logic [DATA_W-1:0]   im_lane1_i,
  input  logic [DATA_W-1:0]   re_lane2_i,
  input  logic [DATA_W-1:0]   im_lane2_i,
  input  logic [DATA_W-1:0]   re_lane3_i,
  input  logic [DATA_W-1:0]   im_lane3_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    mag_lane0_o,
  output logic [OUT_W-1:0]    mag_lane1_o,
  output logic [OUT_W-1:0]    mag_lane2_o,
  output logic [OUT_W-1:0]    mag_lane3_o,
  output logic                frame_end_o
);

  localparam int unsigned S         = CORDIC_STAGES;
  localparam int unsigned PIPE      = S + 3;
  localparam int unsigned CNT_W     = LOG2_POINTS;
  localparam int unsigned BEATS_RAW = (1 << LOG2_POINTS) / LANES;
  localparam int unsigned BEATS     = (BEATS_RAW == 0) ? 1 : BEATS_RAW;
  localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(BEATS - 1);

  cml_mode_e         mag_mode_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PIPE-1:0]   valid_q;
  logic [PIPE-1:0]   last_q;
  logic [S:0]        mode_q;
  logic              adv, accept, is_last;

  logic [DATA_W-1:0] re_in [LANES_MAX];
  logic [DATA_W-1:0] im_in [LANES_MAX];
  logic [OUT_W-1:0]  mag   [LANES_MAX];

  assign re_in = '{re_lane0_i, re_lane1_i, re_lane2_i, re_lane3_i};
  assign im_in = '{im_lane0_i, im_lane1_i, im_lane2_i, im_lane3_i};

  // The pipe moves whenever the output beat is not held by the receiver.
  assign adv        = !(valid_q[PIPE-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign is_last    = (cnt_q == LAST_BEAT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_mode_q <= MODE_CORDIC;
      cnt_q      <= '0;
      valid_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        mag_mode_q <= cml_mode_e'(cfg_wdata_i);
      end
      if (accept) begin
        cnt_q <= is_last ? '0 : cnt_q + 1'b1;
      end
      if (adv) begin
        valid_q <= {valid_q[PIPE-2:0], in_valid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q <= {last_q[PIPE-2:0], is_last};
      mode_q <= {mode_q[S-1:0], (mag_mode_q == MODE_APPROX)};
    end
  end

  for (genvar l = 0; l < LANES_MAX; l++) begin : g_lane
    if (l < LANES) begin : g_on
      logic [DATA_W-1:0] xc [S+1];
      logic [DATA_W-1:0] yc [S+1];
      logic [DATA_W-1:0] abs_re, abs_im, mx, mn, apx;
      logic [DATA_W-1:0] x0_q, y0_q;
      logic              re_gt;
      cml_cell_ctrl_t    fin_ctrl;

      assign abs_re = re_in[l][DATA_W-1] ? -re_in[l] : re_in[l];
      assign abs_im = im_in[l][DATA_W-1] ? -im_in[l] : im_in[l];
      assign re_gt  = $signed(abs_re) > $signed(abs_im);
      assign mx     = re_gt ? abs_re : abs_im;
      assign mn     = re_gt ? abs_im : abs_re;
      assign apx    = mx + DATA_W'($signed(mn) >>> 2) + DATA_W'($signed(mn) >>> 3);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          x0_q <= (mag_mode_q == MODE_APPROX) ? apx : abs_re;
          y0_q <= im_in[l];
        end
      end

      assign xc[0] = x0_q;
      assign yc[0] = y0_q;

      for (genvar k = 0; k < S; k++) begin : g_cell
        cml_cell_ctrl_t ctrl;
        assign ctrl.en     = adv;
        assign ctrl.approx = mode_q[k];

        cml_cell #(
          .SHIFT (k)
        ) u_cell (
          .clk_i  (clk_i),
          .ctrl_i (ctrl),
          .x_i    (xc[k]),
          .y_i    (yc[k]),
          .x_o    (xc[k+1]),
          .y_o    (yc[k+1])
        );
      end

      assign fin_ctrl.en     = adv;
      assign fin_ctrl.approx = mode_q[S];

      cml_finish u_finish (
        .clk_i  (clk_i),
        .ctrl_i (fin_ctrl),
        .x_i    (xc[S]),
        .mag_o  (mag[l])
      );
    end else begin : g_off
      assign mag[l] = '0;
    end
  end

  assign out_valid_o = valid_q[PIPE-1];
  assign frame_end_o = last_q[PIPE-1];
  assign mag_lane0_o = mag[0];
  assign mag_lane1_o = mag[1];
  assign mag_lane2_o = mag[2];
  assign mag_lane3_o = mag[3];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_BEAT)
    else $error("beat counter ran past the frame length");

  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> cnt_q == '0)
    else $error("beat counter did not wrap after the last beat");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipe moved while the output beat was stalled");

  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !valid_q[PIPE-2] |=> !out_valid_o)
    else $error("output beat appeared without a beat behind it");

endmodule
